[rtl/core/cpfm_pkg.sv]
// Shared constants and types for the capture period frequency meter.
// Used by the channel interfaces and the top level; depends on nothing.
package cpfm_pkg;

    localparam int CAPTURE_WIDTH   = 32;
    localparam int QUOT_WIDTH      = 32;
    localparam int RATE_WIDTH      = 33;
    localparam int BASE_WIDTH      = 43;
    localparam int HZ_WIDTH        = 23;
    localparam int MICRO_WIDTH     = 20;
    localparam int REM_WIDTH       = 10;
    localparam int PRESCALE_WIDTH  = 4;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam int MILLI_SCALE = 1000;

    // Reciprocal of 1000 scaled by 2^38; exact for every 32-bit dividend.
    localparam logic [28:0] RECIP_1000  = 29'd274877907;
    localparam int          RECIP_SHIFT = 38;
    localparam int          PROD_WIDTH  = QUOT_WIDTH + 29;

    localparam logic [31:0] OFFSET_RESET = 32'd1352;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENABLE       = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLOCK_RATE   = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RATE_OFFSET  = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESCALE_EXP = 8'd3;

    typedef struct packed {
        logic [31:0]            period_ticks;
        logic [QUOT_WIDTH-1:0]  freq_millihz;
        logic [HZ_WIDTH-1:0]    freq_hz;
        logic [MICRO_WIDTH-1:0] freq_micro;
        logic                   zero_period;
        logic                   saturated;
    } result_t;

endpackage

[rtl/core/cpfm_if.sv]
// Valid/ready channel interfaces for capture pairs, results and register writes.
// Depends on cpfm_pkg for field widths.
interface cpfm_capture_if import cpfm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CAPTURE_WIDTH-1:0] first_capture;
    logic [CAPTURE_WIDTH-1:0] second_capture;

    modport source (output valid, output first_capture, output second_capture, input ready);
    modport sink (input valid, input first_capture, input second_capture, output ready);
endinterface

interface cpfm_result_if import cpfm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [31:0]            period_ticks;
    logic [QUOT_WIDTH-1:0]  freq_millihz;
    logic [HZ_WIDTH-1:0]    freq_hz;
    logic [MICRO_WIDTH-1:0] freq_micro;
    logic                   zero_period;
    logic                   saturated;

    modport source (output valid, output period_ticks, output freq_millihz, output freq_hz,
                    output freq_micro, output zero_period, output saturated, input ready);
    modport sink (input valid, input period_ticks, input freq_millihz, input freq_hz,
                  input freq_micro, input zero_period, input saturated, output ready);
endinterface

interface cpfm_cfg_if import cpfm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/capture_period_frequency_meter.sv]
// Top level of the capture period frequency meter: register file, rate and
// base stages, pipelined restoring divider, decimal split and output skid.
// Depends on cpfm_pkg and the channel interfaces in cpfm_if.sv.

// The meter takes one capture pair per clock cycle while the pipeline advances
// and returns results in the order the pairs were accepted; a pair passes three
// setup stages, a 32-stage restoring divider that retires one quotient bit per
// stage, three stages that split the result into hertz and micro parts, and the output register.
// While enable is 0, pairs are still accepted but produce no result. An output
// register backed by a one-beat skid stage lets the pipeline keep moving while
// a finished beat waits; the pipeline only holds once the skid stage is full.
// Register writes are always taken and must only be issued while no pair is
// in flight.
module capture_period_frequency_meter
    import cpfm_pkg::*;
#(
    parameter int COUNT_WIDTH      = 32,
    parameter int MAX_PRESCALE_EXP = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    cpfm_capture_if.sink   capture,
    cpfm_result_if.source  result,
    cpfm_cfg_if.sink       cfg
);

    localparam int DIV_STEPS = QUOT_WIDTH;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] rem;
        logic [COUNT_WIDTH-1:0] period;
        logic [QUOT_WIDTH-1:0]  low;
        logic [QUOT_WIDTH-1:0]  quot;
        logic                   zero;
        logic                   sat;
    } div_stage_t;

    logic                      enable_reg;
    logic [31:0]               clock_rate_reg;
    logic [31:0]               rate_offset_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_reg;

    logic adv;

    logic                      s1_valid_reg;
    logic [COUNT_WIDTH-1:0]    s1_period_reg;
    logic [RATE_WIDTH-1:0]     s1_rate_reg;
    logic [PRESCALE_WIDTH-1:0] s1_exp_reg;

    logic                      s2_valid_reg;
    logic [COUNT_WIDTH-1:0]    s2_period_reg;
    logic [BASE_WIDTH-1:0]     s2_base_reg;
    logic                      s2_zero_reg;

    logic                      dv_valid_reg [DIV_STEPS+1];
    div_stage_t                dv_reg [DIV_STEPS+1];

    logic                      m1_valid_reg;
    logic [PROD_WIDTH-1:0]     m1_prod_reg;
    logic [QUOT_WIDTH-1:0]     m1_freq_reg;
    logic [31:0]               m1_period_reg;
    logic                      m1_zero_reg;
    logic                      m1_sat_reg;

    logic                      m2_valid_reg;
    logic [HZ_WIDTH-1:0]       m2_hz_reg;
    logic [REM_WIDTH-1:0]      m2_rem_reg;
    logic [QUOT_WIDTH-1:0]     m2_freq_reg;
    logic [31:0]               m2_period_reg;
    logic                      m2_zero_reg;
    logic                      m2_sat_reg;

    logic                      m3_valid_reg;
    result_t                   m3_reg;

    logic                      out_valid_reg;
    result_t                   out_reg;
    logic                      skid_valid_reg;
    result_t                   skid_reg;

    logic [CAPTURE_WIDTH-1:0]  diff;
    logic [PRESCALE_WIDTH-1:0] exp_sat;
    logic signed [33:0]        rate_sum;
    logic [RATE_WIDTH-1:0]     rate_clamped;
    logic [RATE_WIDTH-1:0]     rate_shifted;
    logic [BASE_WIDTH-1:0]     base_next;
    logic [COUNT_WIDTH-1:0]    base_hi;
    logic [QUOT_WIDTH-1:0]     freq_sel;
    logic [HZ_WIDTH-1:0]       hz_next;
    logic [QUOT_WIDTH-1:0]     hz_times;
    logic [QUOT_WIDTH-1:0]     rem_full;
    logic                      take_out;

    // Register file.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            clock_rate_reg  <= '0;
            rate_offset_reg <= OFFSET_RESET;
            prescale_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ENABLE:       enable_reg      <= cfg.data[0];
                CFG_CLOCK_RATE:   clock_rate_reg  <= cfg.data;
                CFG_RATE_OFFSET:  rate_offset_reg <= cfg.data;
                CFG_PRESCALE_EXP: prescale_reg    <= cfg.data[PRESCALE_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // The whole pipeline moves unless the skid stage is occupied.
    assign adv           = !skid_valid_reg;
    assign capture.ready = adv;

    // Stage 1: period, clamped rate and limited prescale exponent.
    always_comb
    begin
        diff     = capture.second_capture - capture.first_capture;
        rate_sum = $signed({2'b00, clock_rate_reg})
                 + $signed({{2{rate_offset_reg[31]}}, rate_offset_reg});
        rate_clamped = rate_sum[33] ? '0 : rate_sum[RATE_WIDTH-1:0];
        exp_sat  = (prescale_reg > PRESCALE_WIDTH'(MAX_PRESCALE_EXP))
                 ? PRESCALE_WIDTH'(MAX_PRESCALE_EXP) : prescale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= capture.valid && enable_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_period_reg <= diff[COUNT_WIDTH-1:0];
            s1_rate_reg   <= rate_clamped;
            s1_exp_reg    <= exp_sat;
        end
    end

    // Stage 2: scaled base in millihertz ticks.
    always_comb
    begin
        rate_shifted = s1_rate_reg >> s1_exp_reg;
        base_next    = BASE_WIDTH'(rate_shifted) * BASE_WIDTH'(MILLI_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_period_reg <= s1_period_reg;
            s2_base_reg   <= base_next;
            s2_zero_reg   <= (s1_period_reg == '0);
        end
    end

    // Stage 3: overflow check. The quotient fits in 32 bits exactly when the
    // base bits above 32 form a value below the period, which then seeds the
    // partial remainder of the divider.
    assign base_hi = COUNT_WIDTH'(s2_base_reg[BASE_WIDTH-1:QUOT_WIDTH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0].rem    <= base_hi;
            dv_reg[0].period <= s2_period_reg;
            dv_reg[0].low    <= s2_base_reg[QUOT_WIDTH-1:0];
            dv_reg[0].quot   <= '0;
            dv_reg[0].zero   <= s2_zero_reg;
            dv_reg[0].sat    <= !s2_zero_reg && (base_hi >= s2_period_reg);
        end
    end

    // Restoring divider, one quotient bit per stage.
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_div
        logic [COUNT_WIDTH:0] shifted;
        logic [COUNT_WIDTH:0] trial;
        logic                 ge;

        always_comb
        begin
            shifted = {dv_reg[i-1].rem, dv_reg[i-1].low[QUOT_WIDTH-1]};
            trial   = shifted - {1'b0, dv_reg[i-1].period};
            ge      = (shifted >= {1'b0, dv_reg[i-1].period});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[i].rem    <= ge ? trial[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
                dv_reg[i].period <= dv_reg[i-1].period;
                dv_reg[i].low    <= {dv_reg[i-1].low[QUOT_WIDTH-2:0], 1'b0};
                dv_reg[i].quot   <= {dv_reg[i-1].quot[QUOT_WIDTH-2:0], ge};
                dv_reg[i].zero   <= dv_reg[i-1].zero;
                dv_reg[i].sat    <= dv_reg[i-1].sat;
            end
        end
    end

    // Stage M1: final frequency and reciprocal product for the split by 1000.
    always_comb
    begin
        if (dv_reg[DIV_STEPS].zero)
        begin
            freq_sel = '0;
        end
        else if (dv_reg[DIV_STEPS].sat)
        begin
            freq_sel = '1;
        end
        else
        begin
            freq_sel = dv_reg[DIV_STEPS].quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_prod_reg   <= PROD_WIDTH'(freq_sel) * PROD_WIDTH'(RECIP_1000);
            m1_freq_reg   <= freq_sel;
            m1_period_reg <= 32'(dv_reg[DIV_STEPS].period);
            m1_zero_reg   <= dv_reg[DIV_STEPS].zero;
            m1_sat_reg    <= dv_reg[DIV_STEPS].sat;
        end
    end

    // Stage M2: whole hertz and the millihertz remainder.
    always_comb
    begin
        hz_next  = m1_prod_reg[RECIP_SHIFT +: HZ_WIDTH];
        hz_times = QUOT_WIDTH'(hz_next) * QUOT_WIDTH'(MILLI_SCALE);
        rem_full = m1_freq_reg - hz_times;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_hz_reg     <= hz_next;
            m2_rem_reg    <= rem_full[REM_WIDTH-1:0];
            m2_freq_reg   <= m1_freq_reg;
            m2_period_reg <= m1_period_reg;
            m2_zero_reg   <= m1_zero_reg;
            m2_sat_reg    <= m1_sat_reg;
        end
    end

    // Stage M3: micro fraction and result assembly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg.period_ticks <= m2_period_reg;
            m3_reg.freq_millihz <= m2_freq_reg;
            m3_reg.freq_hz      <= m2_hz_reg;
            m3_reg.freq_micro   <= MICRO_WIDTH'(m2_rem_reg) * MICRO_WIDTH'(MILLI_SCALE);
            m3_reg.zero_period  <= m2_zero_reg;
            m3_reg.saturated    <= m2_sat_reg;
        end
    end

    // Output register with a one-beat skid stage.
    assign take_out = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= m3_valid_reg;
            end
        end
        else if (adv && m3_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : m3_reg;
        end
        else if (adv && m3_valid_reg)
        begin
            skid_reg <= m3_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.period_ticks = out_reg.period_ticks;
    assign result.freq_millihz = out_reg.freq_millihz;
    assign result.freq_hz      = out_reg.freq_hz;
    assign result.freq_micro   = out_reg.freq_micro;
    assign result.zero_period  = out_reg.zero_period;
    assign result.saturated    = out_reg.saturated;

endmodule
